// ===== rtl/swkv_pkg.sv =====
// ----------------------------------------------------------------------------
// swkv_pkg
// Shared constants and types for the sliding-window KV evictor.
// ----------------------------------------------------------------------------
`default_nettype none

package swkv_pkg;

    localparam int QUEUE_DEPTH = 32;

    localparam logic [1:0] KIND_EVICT = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_FULL  = 2'd2;

    // one age-queue entry held by a cell
    typedef struct packed {
        logic        valid;
        logic        latest;   // entry still matches the record of its id
        logic [63:0] id;
        logic [31:0] pos;
        logic [31:0] bytes;
    } swkv_entry_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic        clear;
        logic        append;
        logic        shift;
        logic        pop_evict;
        logic [63:0] front_id;
        logic [63:0] upd_id;
        logic [31:0] upd_pos;
        logic [31:0] upd_bytes;
    } swkv_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/swkv_cell.sv =====
// ----------------------------------------------------------------------------
// swkv_cell
// One slot of the age queue; shifts toward the front on a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module swkv_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire swkv_pkg::swkv_ctl_t  ctl,
    input  wire logic                 prev_valid,
    input  wire swkv_pkg::swkv_entry_t nxt,
    output swkv_pkg::swkv_entry_t      ent
);
    import swkv_pkg::*;

    swkv_entry_t ent_reg;
    swkv_entry_t ent_next;

    always_comb
    begin
        ent_next = ent_reg;
        if (ctl.clear)
        begin
            ent_next.valid = 1'b0;
        end
        else if (ctl.append)
        begin
            if (ent_reg.valid && ent_reg.id == ctl.upd_id)
            begin
                // record for this id now holds the new position
                ent_next.latest = (ent_reg.pos == ctl.upd_pos);
            end
            else if (!ent_reg.valid && prev_valid)
            begin
                ent_next.valid  = 1'b1;
                ent_next.latest = 1'b1;
                ent_next.id     = ctl.upd_id;
                ent_next.pos    = ctl.upd_pos;
                ent_next.bytes  = ctl.upd_bytes;
            end
        end
        else if (ctl.shift)
        begin
            ent_next = nxt;
            // evicting the front drops its id record
            if (ctl.pop_evict && nxt.id == ctl.front_id)
            begin
                ent_next.latest = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= '0;
        end
        else
        begin
            ent_reg <= ent_next;
        end
    end

    assign ent = ent_reg;

endmodule

`default_nettype wire

// ===== rtl/sliding_window_kv_evictor_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_kv_evictor_top
// Sliding-window KV cache evictor built on a chain of queue cells.
// ----------------------------------------------------------------------------
// When an upsert request is taken, it is appended to the first empty cell
// and every cell with the same id re-evaluates whether it still matches
// that id's newest position. Then the front entry is popped while it lies
// below the window (each pop shifts the whole chain by one), and a done
// summary closes the request. A clear or a refused upsert gives its single
// result with no pop phase. A result waits in the output register; the
// block stalls while it is not taken. The window register is to be written
// only while idle, which the block itself does not enforce; a zero write is stored as one.
`default_nettype none

module sliding_window_kv_evictor_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_wdata,   // window_tokens
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,     // kv_id, token_pos, entry_bytes
    input  wire logic         s_tuser,     // cmd
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [191:0]      m_tdata,     // evicted_id, evicted_pos,
                                           // evicted_bytes, resident_bytes
    output logic [1:0]        m_tuser,     // result_kind
    output logic              m_tlast      // last
);
    import swkv_pkg::*;

    typedef enum logic {ST_IDLE, ST_POP} state_t;

    state_t      state_reg;
    logic [31:0] window_reg;
    logic [31:0] min_reg;        // oldest position still inside the window
    logic [63:0] total_reg;
    logic        out_vld_reg;
    logic [1:0]  out_kind_reg;
    logic [63:0] out_id_reg;
    logic [31:0] out_pos_reg;
    logic [31:0] out_bytes_reg;
    logic [63:0] out_total_reg;
    logic        out_last_reg;

    swkv_entry_t ent [QUEUE_DEPTH];
    swkv_ctl_t   ctl;

    logic        out_free;
    logic        acc;
    logic        full;
    logic        pop_go;
    logic [63:0] in_id;
    logic [31:0] in_pos;
    logic [31:0] in_bytes;
    logic [64:0] sum;
    logic [63:0] total_add;
    logic [63:0] total_sub;
    logic [31:0] min_new;

    assign in_id    = s_tdata[63:0];
    assign in_pos   = s_tdata[95:64];
    assign in_bytes = s_tdata[127:96];

    assign out_free = !out_vld_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign acc      = s_tvalid && s_tready;
    assign full     = ent[QUEUE_DEPTH-1].valid;
    assign pop_go   = (state_reg == ST_POP) && out_free && ent[0].valid
                      && (ent[0].pos < min_reg);

    // saturating add of the new entry, flooring subtract of the popped one
    assign sum       = {1'b0, total_reg} + {33'd0, in_bytes};
    assign total_add = sum[64] ? '1 : sum[63:0];
    assign total_sub = (total_reg >= {32'd0, ent[0].bytes})
                       ? total_reg - {32'd0, ent[0].bytes} : '0;
    assign min_new   = (in_pos > window_reg) ? in_pos - window_reg : '0;

    always_comb
    begin
        ctl           = '0;
        ctl.clear     = acc && s_tuser;
        ctl.append    = acc && !s_tuser && !full;
        ctl.shift     = pop_go;
        ctl.pop_evict = pop_go && ent[0].latest;
        ctl.front_id  = ent[0].id;
        ctl.upd_id    = in_id;
        ctl.upd_pos   = in_pos;
        ctl.upd_bytes = in_bytes;
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            logic        prev_v;
            swkv_entry_t nxt_e;
            if (g == 0)
            begin : g_first
                assign prev_v = 1'b1;
            end
            else
            begin : g_mid
                assign prev_v = ent[g-1].valid;
            end
            if (g == QUEUE_DEPTH - 1)
            begin : g_tail
                assign nxt_e = '0;
            end
            else
            begin : g_body
                assign nxt_e = ent[g+1];
            end
            swkv_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .prev_valid (prev_v),
                .nxt        (nxt_e),
                .ent        (ent[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= 32'd1024;
            min_reg       <= '0;
            total_reg     <= '0;
            out_vld_reg   <= 1'b0;
            out_kind_reg  <= KIND_DONE;
            out_id_reg    <= '0;
            out_pos_reg   <= '0;
            out_bytes_reg <= '0;
            out_total_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_reg <= (cfg_wdata == '0) ? 32'd1 : cfg_wdata;
            end
            if (out_free)
            begin
                out_vld_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (acc)
                    begin
                        out_id_reg    <= '0;
                        out_pos_reg   <= '0;
                        out_bytes_reg <= '0;
                        out_last_reg  <= 1'b1;
                        if (s_tuser)
                        begin
                            total_reg     <= '0;
                            out_vld_reg   <= 1'b1;
                            out_kind_reg  <= KIND_DONE;
                            out_total_reg <= '0;
                        end
                        else if (full)
                        begin
                            out_vld_reg   <= 1'b1;
                            out_kind_reg  <= KIND_FULL;
                            out_total_reg <= total_reg;
                        end
                        else
                        begin
                            total_reg <= total_add;
                            min_reg   <= min_new;
                            state_reg <= ST_POP;
                        end
                    end
                end
                ST_POP:
                begin
                    if (out_free)
                    begin
                        if (pop_go)
                        begin
                            if (ent[0].latest)
                            begin
                                total_reg     <= total_sub;
                                out_vld_reg   <= 1'b1;
                                out_kind_reg  <= KIND_EVICT;
                                out_id_reg    <= ent[0].id;
                                out_pos_reg   <= ent[0].pos;
                                out_bytes_reg <= ent[0].bytes;
                                out_total_reg <= total_sub;
                                out_last_reg  <= 1'b0;
                            end
                        end
                        else
                        begin
                            out_vld_reg   <= 1'b1;
                            out_kind_reg  <= KIND_DONE;
                            out_id_reg    <= '0;
                            out_pos_reg   <= '0;
                            out_bytes_reg <= '0;
                            out_total_reg <= total_reg;
                            out_last_reg  <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_total_reg, out_bytes_reg, out_pos_reg, out_id_reg};

`ifndef SYNTHESIS
    // the chain stays packed toward the front
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ent[1].valid |-> ent[0].valid)
        else $error("queue cells not contiguous");

    // a clear request empties the chain
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |=> !ent[0].valid)
        else $error("clear left entries behind");

    // an upsert into a full queue is refused at once
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser && full)
        |=> (m_tvalid && m_tuser == KIND_FULL && m_tlast))
        else $error("full queue upsert not refused");

    // evictions are never the final result of a request
    a_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_EVICT) |-> !m_tlast)
        else $error("eviction marked last");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/sliding_window_kv_evictor_top_test.sv =====
// ----------------------------------------------------------------------------
// sliding_window_kv_evictor_top_test
// Stream-level check of the sliding-window KV evictor against a local model.
// ----------------------------------------------------------------------------
// Requests are queued by the stimulus block and driven by a clocked driver.
// Each accepted request runs through a behavioral copy of the evictor, which
// records its expected results. A clocked monitor compares every accepted
// result with the oldest expectation. Both sides idle at random, except
// during one quiet stretch.
`timescale 1ns / 100ps

module sliding_window_kv_evictor_top_test;
    import swkv_pkg::*;

    localparam logic CMD_UPSERT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;
    localparam int   RUN_LIMIT  = 400000;
    localparam int   REQ_SLOTS  = 1024;
    localparam int   RES_SLOTS  = 1024;

    typedef struct packed {
        logic        cmd;
        logic [63:0] kv_id;
        logic [31:0] token_pos;
        logic [31:0] entry_bytes;
    } kv_req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] ev_id;
        logic [31:0] ev_pos;
        logic [31:0] ev_bytes;
        logic [63:0] resident;
        logic        last;
    } kv_res_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [31:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    sliding_window_kv_evictor_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // ---------------------------------------------------------------------
    // Evictor model state
    // ---------------------------------------------------------------------
    logic [31:0]  win_len;
    logic [63:0]  age_id  [QUEUE_DEPTH];
    logic [31:0]  age_pos [QUEUE_DEPTH];
    logic [31:0]  age_sz  [QUEUE_DEPTH];
    int           age_head;
    int           age_cnt;
    logic         rec_valid [QUEUE_DEPTH];
    logic [63:0]  rec_id    [QUEUE_DEPTH];
    logic [31:0]  rec_pos   [QUEUE_DEPTH];
    logic [63:0]  resident_sum;

    // pending requests and expected results, each a write and a read count
    kv_req_t req_buf [REQ_SLOTS];
    int      req_wr;
    int      req_rd;
    kv_res_t exp_buf [RES_SLOTS];
    int      exp_wr;
    int      exp_rd;

    int  fail_count;
    int  evict_count;
    int  refuse_count;
    int  req_sent;
    int  res_seen;
    int  cycle_count;
    bit  quiet;

    function automatic kv_res_t mk_res(logic [1:0] k, logic [63:0] id, logic [31:0] p,
                                       logic [31:0] b, logic l);
        kv_res_t r;
        r.kind = k;
        r.ev_id = id;
        r.ev_pos = p;
        r.ev_bytes = b;
        r.resident = resident_sum;
        r.last = l;
        return r;
    endfunction

    function automatic kv_req_t mk_req(logic c, logic [63:0] id, logic [31:0] p,
                                       logic [31:0] b);
        kv_req_t q;
        q.cmd = c;
        q.kv_id = id;
        q.token_pos = p;
        q.entry_bytes = b;
        return q;
    endfunction

    function automatic void queue_req(kv_req_t q);
        req_buf[req_wr % REQ_SLOTS] = q;
        req_wr++;
    endfunction

    function automatic void expect_res(kv_res_t r);
        exp_buf[exp_wr % RES_SLOTS] = r;
        exp_wr++;
    endfunction

    function automatic int find_rec(logic [63:0] id);
        for (int i = 0; i < QUEUE_DEPTH; i++)
            if (rec_valid[i] && rec_id[i] == id)
                return i;
        return -1;
    endfunction

    task automatic wipe_state();
        for (int i = 0; i < QUEUE_DEPTH; i++)
            rec_valid[i] = 1'b0;
        age_head = 0;
        age_cnt = 0;
        resident_sum = '0;
    endtask

    // model one accepted request, recording its results
    task automatic predict_evictions(kv_req_t q);
        int          slot;
        int          tail;
        int          h;
        int          m;
        int          n;
        logic [31:0] floor_pos;
        logic [64:0] sum;
        n = 0;
        if (q.cmd == CMD_CLEAR)
        begin
            wipe_state();
            expect_res(mk_res(KIND_DONE, '0, '0, '0, 1'b1));
            return;
        end
        if (age_cnt >= QUEUE_DEPTH)
        begin
            expect_res(mk_res(KIND_FULL, '0, '0, '0, 1'b1));
            return;
        end
        slot = find_rec(q.kv_id);
        if (slot < 0)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
                if (!rec_valid[i])
                begin
                    slot = i;
                    break;
                end
            if (slot >= 0)
            begin
                rec_valid[slot] = 1'b1;
                rec_id[slot] = q.kv_id;
            end
        end
        if (slot >= 0)
            rec_pos[slot] = q.token_pos;
        tail = (age_head + age_cnt) % QUEUE_DEPTH;
        age_id[tail] = q.kv_id;
        age_pos[tail] = q.token_pos;
        age_sz[tail] = q.entry_bytes;
        age_cnt++;
        sum = {1'b0, resident_sum} + {33'd0, q.entry_bytes};
        resident_sum = sum[64] ? '1 : sum[63:0];
        floor_pos = (q.token_pos > win_len) ? q.token_pos - win_len : '0;
        while (age_cnt > 0)
        begin
            h = age_head;
            if (age_pos[h] >= floor_pos)
                break;
            age_head = (h + 1) % QUEUE_DEPTH;
            age_cnt--;
            m = find_rec(age_id[h]);
            if (m >= 0 && rec_pos[m] == age_pos[h])
            begin
                rec_valid[m] = 1'b0;
                resident_sum = (resident_sum >= {32'd0, age_sz[h]})
                               ? resident_sum - {32'd0, age_sz[h]} : '0;
                if (n < QUEUE_DEPTH - 1)
                begin
                    expect_res(mk_res(KIND_EVICT, age_id[h], age_pos[h], age_sz[h], 1'b0));
                    n++;
                end
            end
        end
        expect_res(mk_res(KIND_DONE, '0, '0, '0, 1'b1));
    endtask

    // ---------------------------------------------------------------------
    // Driver: takes the next request when the current one is accepted
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_evictions(mk_req(s_tuser, s_tdata[63:0], s_tdata[95:64],
                                         s_tdata[127:96]));
                req_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (req_rd != req_wr && (quiet || $urandom_range(99) >= 33))
                begin
                    kv_req_t q;
                    q = req_buf[req_rd % REQ_SLOTS];
                    req_rd++;
                    s_tvalid <= 1'b1;
                    s_tuser  <= q.cmd;
                    s_tdata  <= {q.entry_bytes, q.token_pos, q.kv_id};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: compares each accepted result with the oldest expectation
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                res_seen++;
                if (exp_rd == exp_wr)
                begin
                    $error("result with no request pending: kind %0d", m_tuser);
                    fail_count++;
                end
                else
                begin
                    kv_res_t e;
                    e = exp_buf[exp_rd % RES_SLOTS];
                    exp_rd++;
                    if (m_tuser !== e.kind)
                    begin
                        $error("result_kind exp %0d got %0d", e.kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[63:0] !== e.ev_id)
                    begin
                        $error("evicted_id exp %h got %h", e.ev_id, m_tdata[63:0]);
                        fail_count++;
                    end
                    if (m_tdata[95:64] !== e.ev_pos)
                    begin
                        $error("evicted_pos exp %h got %h", e.ev_pos, m_tdata[95:64]);
                        fail_count++;
                    end
                    if (m_tdata[127:96] !== e.ev_bytes)
                    begin
                        $error("evicted_bytes exp %h got %h", e.ev_bytes, m_tdata[127:96]);
                        fail_count++;
                    end
                    if (m_tdata[191:128] !== e.resident)
                    begin
                        $error("resident_bytes exp %h got %h", e.resident, m_tdata[191:128]);
                        fail_count++;
                    end
                    if (m_tlast !== e.last)
                    begin
                        $error("last exp %0d got %0d", e.last, m_tlast);
                        fail_count++;
                    end
                    if (e.kind == KIND_EVICT)
                        evict_count++;
                    if (e.kind == KIND_FULL)
                        refuse_count++;
                end
            end
            m_tready <= quiet || ($urandom_range(99) >= 33);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // wait until queued requests are sent and all results are back
    task automatic drain();
        while (req_rd != req_wr || s_tvalid || exp_rd != exp_wr)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // window change, only while the block is idle
    task automatic set_window(logic [31:0] w);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we    <= 1'b0;
        win_len = (w == 0) ? 32'd1 : w;
    endtask

    // a run of upserts at non-decreasing positions over a small id pool
    task automatic stream_run(int len, int id_pool, logic [31:0] start, int step_max,
                              bit big_sizes);
        logic [31:0] p;
        logic [63:0] base;
        base = rand64();
        p = start;
        for (int i = 0; i < len; i++)
        begin
            p = p + $urandom_range(step_max);
            queue_req(mk_req(CMD_UPSERT, base ^ {32'd0, $urandom_range(id_pool - 1)}, p,
                big_sizes ? $urandom : $urandom_range(4096)));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        quiet       = 1'b0;
        fail_count  = 0;
        evict_count = 0;
        refuse_count = 0;
        req_sent    = 0;
        res_seen    = 0;
        cycle_count = 0;
        req_wr      = 0;
        req_rd      = 0;
        exp_wr      = 0;
        exp_rd      = 0;
        win_len     = 32'd1024;
        wipe_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset window, reuse of an id, superseded entry, eviction
        queue_req(mk_req(CMD_UPSERT, 64'h0, 32'd0, 32'd0));
        queue_req(mk_req(CMD_UPSERT, '1, 32'd10, '1));
        queue_req(mk_req(CMD_UPSERT, 64'h0, 32'd20, 32'd5));
        queue_req(mk_req(CMD_UPSERT, 64'h55, 32'd2000, 32'd7));
        queue_req(mk_req(CMD_UPSERT, 64'h66, '1, '1));
        queue_req(mk_req(CMD_CLEAR, rand64(), $urandom, $urandom));
        drain();

        // zero write taken as one; fill the queue to refusal
        set_window(32'd0);
        for (int i = 0; i < QUEUE_DEPTH + 2; i++)
            queue_req(mk_req(CMD_UPSERT, 64'(i), 32'd100, '1));
        // one far position pops every older entry in one request
        drain();
        queue_req(mk_req(CMD_CLEAR, '0, '0, '0));
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            queue_req(mk_req(CMD_UPSERT, 64'hA000 + 64'(i), 32'(i), 32'd3));
        queue_req(mk_req(CMD_UPSERT, 64'hB, 32'd5000, 32'd1));
        drain();

        // the largest entry sizes with the widest window
        set_window('1);
        for (int i = 0; i < 4; i++)
            queue_req(mk_req(CMD_UPSERT, 64'hC0 + 64'(i), 32'd1 + 32'(i), '1));
        queue_req(mk_req(CMD_CLEAR, '0, '0, '0));
        drain();

        // random phases over several windows
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_window(32'd1);
                1: set_window(32'd8);
                2: set_window(32'd64);
                3: set_window($urandom);
                4: set_window(32'd16);
                default: set_window(32'd1024);
            endcase
            quiet = (ph == 2);
            stream_run(16, 6, $urandom_range(1000), 6, ph == 3);
            if ($urandom_range(2) == 0)
                queue_req(mk_req(CMD_CLEAR, rand64(), $urandom, $urandom));
            // noise: arbitrary fields, both commands
            for (int i = 0; i < 4; i++)
                queue_req(mk_req($urandom_range(3) == 0, rand64(), $urandom, $urandom));
            drain();
        end
        quiet = 1'b0;

        $display("%0d requests, %0d results: %0d evictions, %0d refusals",
                 req_sent, res_seen, evict_count, refuse_count);
        $display("windows 0, 1, 8, 16, 64, 1024, max and random exercised");
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
